// File: rtl/core/pea_pkg.sv
`timescale 1ns / 1ps
package pea_pkg;

    localparam int MAX_EXTENTS = 64;
    localparam int PAGE_BITS   = 20;
    localparam int COUNT_BITS  = PAGE_BITS + 1;
    localparam int IDX_BITS    = $clog2(MAX_EXTENTS);
    localparam int CNT_BITS    = $clog2(MAX_EXTENTS + 1);
    localparam int CFG_BITS    = COUNT_BITS;

    // Command codes.
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_INIT  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    // Configuration register indexes.
    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_PAGES = 1'b1;

    typedef struct packed {
        logic [1:0]            cmd;
        logic [PAGE_BITS-1:0]  page_index;
        logic [COUNT_BITS-1:0] page_count;
    } cmd_t;

    typedef struct packed {
        logic [PAGE_BITS-1:0] alloc_page;
        logic [1:0]           status;
    } result_t;

    // Datapath operations requested by the controller.
    localparam logic [2:0] OP_NONE   = 3'd0;
    localparam logic [2:0] OP_LATCH  = 3'd1;
    localparam logic [2:0] OP_READ   = 3'd2;
    localparam logic [2:0] OP_WRITE  = 3'd3;
    localparam logic [2:0] OP_MOVE   = 3'd4;

    // Controller to datapath.
    typedef struct packed {
        logic [2:0]          op;
        logic [IDX_BITS-1:0] rd_idx;
        logic [IDX_BITS-1:0] wr_idx;
        logic                wr_from_rd;
        logic [PAGE_BITS-1:0]  wr_start;
        logic [COUNT_BITS-1:0] wr_len;
    } dp_cmd_t;

    // Datapath to controller: registered read data.
    typedef struct packed {
        logic [PAGE_BITS-1:0]  start;
        logic [COUNT_BITS-1:0] len;
    } dp_stat_t;

    // Saturate a run so that it ends at or before the top of page space.
    function automatic logic [COUNT_BITS-1:0] clamp_len(
        input logic [PAGE_BITS-1:0]  start,
        input logic [COUNT_BITS-1:0] len
    );
        logic [COUNT_BITS-1:0] room;
        room = (COUNT_BITS'(1) << PAGE_BITS) - {1'b0, start};
        return (len > room) ? room : len;
    endfunction

endpackage

// File: rtl/core/pea_table.sv
`timescale 1ns / 1ps
module pea_table (
    input  logic              clk,
    input  pea_pkg::dp_cmd_t  dcmd,
    output pea_pkg::dp_stat_t dstat
);
    import pea_pkg::*;

    logic [PAGE_BITS-1:0]  start_mem [MAX_EXTENTS];
    logic [COUNT_BITS-1:0] len_mem   [MAX_EXTENTS];
    logic [PAGE_BITS-1:0]  rd_start_reg;
    logic [COUNT_BITS-1:0] rd_len_reg;

    // One registered read port and one write port; a move writes the last read beat.
    always_ff @(posedge clk)
    begin
        if (dcmd.op == OP_READ)
        begin
            rd_start_reg <= start_mem[dcmd.rd_idx];
            rd_len_reg   <= len_mem[dcmd.rd_idx];
        end
        if (dcmd.op == OP_WRITE || dcmd.op == OP_MOVE)
        begin
            start_mem[dcmd.wr_idx] <= dcmd.wr_from_rd ? rd_start_reg : dcmd.wr_start;
            len_mem[dcmd.wr_idx]   <= dcmd.wr_from_rd ? rd_len_reg : dcmd.wr_len;
        end
    end

    assign dstat.start = rd_start_reg;
    assign dstat.len   = rd_len_reg;

endmodule

// File: rtl/core/pea_ctrl.sv
`timescale 1ns / 1ps
module pea_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  pea_pkg::cmd_t                   cmd_in,
    input  logic [pea_pkg::PAGE_BITS-1:0]   region_base,
    input  logic [pea_pkg::COUNT_BITS-1:0]  region_pages,
    output pea_pkg::dp_cmd_t                dcmd,
    input  pea_pkg::dp_stat_t               dstat,
    output logic                            done,
    output pea_pkg::result_t                result
);
    import pea_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_AREAD  = 4'd1;
    localparam logic [3:0] S_ACHK   = 4'd2;
    localparam logic [3:0] S_FREAD  = 4'd3;
    localparam logic [3:0] S_FCHK   = 4'd4;
    localparam logic [3:0] S_FLREAD = 4'd5;
    localparam logic [3:0] S_FLCHK  = 4'd6;
    localparam logic [3:0] S_DREAD  = 4'd7;
    localparam logic [3:0] S_DMOVE  = 4'd8;
    localparam logic [3:0] S_UREAD  = 4'd9;
    localparam logic [3:0] S_UMOVE  = 4'd10;
    localparam logic [3:0] S_REPLY  = 4'd11;
    localparam logic [3:0] S_RRD    = 4'd12;
    localparam logic [3:0] S_RCHK   = 4'd13;

    logic [3:0]            state_reg, state_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CNT_BITS-1:0]   pos_reg, pos_next;
    logic [CNT_BITS-1:0]   k_reg, k_next;
    logic [PAGE_BITS-1:0]  p_reg, p_next;
    logic [COUNT_BITS-1:0] n_reg, n_next;
    logic [PAGE_BITS-1:0]  page_reg, page_next;
    logic [1:0]            status_reg, status_next;
    logic                  ltouch_reg, ltouch_next;
    logic [COUNT_BITS-1:0] llen_reg, llen_next;
    logic                  done_reg, done_next;
    logic [COUNT_BITS-1:0] rem_len;
    logic [PAGE_BITS:0]    end_l;
    logic [PAGE_BITS:0]    end_p;
    logic [COUNT_BITS-1:0] init_len;

    assign rem_len  = dstat.len - n_reg;
    assign end_l    = {1'b0, dstat.start} + dstat.len[PAGE_BITS:0];
    assign end_p    = {1'b0, p_reg} + n_reg[PAGE_BITS:0];
    assign init_len = clamp_len(region_base, region_pages);

    // Sequencer: scans and shifts the table one entry per step.
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        k_next      = k_reg;
        p_next      = p_reg;
        n_next      = n_reg;
        page_next   = page_reg;
        status_next = status_reg;
        ltouch_next = ltouch_reg;
        llen_next   = llen_reg;
        done_next   = 1'b0;
        dcmd        = '0;
        dcmd.op     = OP_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    p_next      = cmd_in.page_index;
                    n_next      = cmd_in.page_count;
                    page_next   = '0;
                    status_next = ST_OK;
                    pos_next    = '0;
                    state_next  = S_REPLY;
                    case (cmd_in.cmd)
                        CMD_ALLOC:
                        begin
                            if (cmd_in.page_count == '0)
                                status_next = ST_ZERO;
                            else if (count_reg == '0)
                                status_next = ST_NOFIT;
                            else
                                state_next = S_AREAD;
                        end
                        CMD_FREE:
                        begin
                            n_next = clamp_len(cmd_in.page_index, cmd_in.page_count);
                            if (cmd_in.page_count == '0)
                                status_next = ST_ZERO;
                            else if (count_reg == '0)
                                state_next = S_UREAD;
                            else
                                state_next = S_FREAD;
                        end
                        CMD_INIT:
                        begin
                            if (init_len == '0)
                                count_next = '0;
                            else
                            begin
                                count_next    = CNT_BITS'(1);
                                dcmd.op       = OP_WRITE;
                                dcmd.wr_idx   = '0;
                                dcmd.wr_start = region_base;
                                dcmd.wr_len   = init_len;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    k_next = count_reg;
                end
            end
            S_AREAD:
            begin
                dcmd.op     = OP_READ;
                dcmd.rd_idx = pos_reg[IDX_BITS-1:0];
                state_next  = S_ACHK;
            end
            S_ACHK:
            begin
                if (n_reg == dstat.len)
                begin
                    page_next  = dstat.start;
                    k_next     = pos_reg;
                    state_next = S_DREAD;
                end
                else if (n_reg < dstat.len)
                begin
                    page_next     = dstat.start + rem_len[PAGE_BITS-1:0];
                    dcmd.op       = OP_WRITE;
                    dcmd.wr_idx   = pos_reg[IDX_BITS-1:0];
                    dcmd.wr_start = dstat.start;
                    dcmd.wr_len   = rem_len;
                    state_next    = S_REPLY;
                end
                else if (pos_reg + 1'b1 == count_reg)
                begin
                    status_next = ST_NOFIT;
                    state_next  = S_REPLY;
                end
                else
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_AREAD;
                end
            end
            // Remove entry k: pull each later entry down by one.
            S_DREAD:
            begin
                if (k_reg + 1'b1 >= count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_REPLY;
                end
                else
                begin
                    dcmd.op     = OP_READ;
                    dcmd.rd_idx = IDX_BITS'(k_reg + 1'b1);
                    state_next  = S_DMOVE;
                end
            end
            S_DMOVE:
            begin
                dcmd.op         = OP_MOVE;
                dcmd.wr_from_rd = 1'b1;
                dcmd.wr_idx     = k_reg[IDX_BITS-1:0];
                k_next          = k_reg + 1'b1;
                state_next      = S_DREAD;
            end
            // Find the first entry whose start is not below p.
            S_FREAD:
            begin
                dcmd.op     = OP_READ;
                dcmd.rd_idx = pos_reg[IDX_BITS-1:0];
                state_next  = S_FCHK;
            end
            S_FCHK:
            begin
                if (dstat.start < p_reg && pos_reg + 1'b1 < count_reg)
                begin
                    pos_next   = pos_reg + 1'b1;
                    state_next = S_FREAD;
                end
                else
                begin
                    if (dstat.start < p_reg)
                        pos_next = pos_reg + 1'b1;
                    state_next = S_FLREAD;
                end
            end
            S_FLREAD:
            begin
                ltouch_next = 1'b0;
                if (pos_reg == '0)
                    state_next = S_RRD;
                else
                begin
                    dcmd.op     = OP_READ;
                    dcmd.rd_idx = IDX_BITS'(pos_reg - 1'b1);
                    state_next  = S_FLCHK;
                end
            end
            S_FLCHK:
            begin
                ltouch_next = (end_l == {1'b0, p_reg});
                llen_next   = dstat.len;
                state_next  = S_RRD;
            end
            S_RRD:
            begin
                if (pos_reg < count_reg)
                begin
                    dcmd.op     = OP_READ;
                    dcmd.rd_idx = pos_reg[IDX_BITS-1:0];
                    state_next  = S_RCHK;
                end
                else if (ltouch_reg)
                begin
                    dcmd.op       = OP_WRITE;
                    dcmd.wr_idx   = IDX_BITS'(pos_reg - 1'b1);
                    dcmd.wr_start = p_reg - llen_reg[PAGE_BITS-1:0];
                    dcmd.wr_len   = llen_reg + n_reg;
                    state_next    = S_REPLY;
                end
                else if (count_reg >= CNT_BITS'(MAX_EXTENTS))
                begin
                    status_next = ST_FULL;
                    state_next  = S_REPLY;
                end
                else
                begin
                    k_next     = count_reg;
                    state_next = S_UREAD;
                end
            end
            S_RCHK:
            begin
                if (ltouch_reg && end_p == {1'b0, dstat.start})
                begin
                    dcmd.op       = OP_WRITE;
                    dcmd.wr_idx   = IDX_BITS'(pos_reg - 1'b1);
                    dcmd.wr_start = p_reg - llen_reg[PAGE_BITS-1:0];
                    dcmd.wr_len   = llen_reg + n_reg + dstat.len;
                    k_next        = pos_reg;
                    state_next    = S_DREAD;
                end
                else if (ltouch_reg)
                begin
                    dcmd.op       = OP_WRITE;
                    dcmd.wr_idx   = IDX_BITS'(pos_reg - 1'b1);
                    dcmd.wr_start = p_reg - llen_reg[PAGE_BITS-1:0];
                    dcmd.wr_len   = llen_reg + n_reg;
                    state_next    = S_REPLY;
                end
                else if (end_p == {1'b0, dstat.start})
                begin
                    dcmd.op       = OP_WRITE;
                    dcmd.wr_idx   = pos_reg[IDX_BITS-1:0];
                    dcmd.wr_start = p_reg;
                    dcmd.wr_len   = dstat.len + n_reg;
                    state_next    = S_REPLY;
                end
                else if (count_reg >= CNT_BITS'(MAX_EXTENTS))
                begin
                    status_next = ST_FULL;
                    state_next  = S_REPLY;
                end
                else
                begin
                    k_next     = count_reg;
                    state_next = S_UREAD;
                end
            end
            // Open a hole at pos: push entries up from the top, then write.
            S_UREAD:
            begin
                if (k_reg <= pos_reg)
                begin
                    dcmd.op       = OP_WRITE;
                    dcmd.wr_idx   = pos_reg[IDX_BITS-1:0];
                    dcmd.wr_start = p_reg;
                    dcmd.wr_len   = n_reg;
                    count_next    = count_reg + 1'b1;
                    state_next    = S_REPLY;
                end
                else
                begin
                    dcmd.op     = OP_READ;
                    dcmd.rd_idx = IDX_BITS'(k_reg - 1'b1);
                    state_next  = S_UMOVE;
                end
            end
            S_UMOVE:
            begin
                dcmd.op         = OP_MOVE;
                dcmd.wr_from_rd = 1'b1;
                dcmd.wr_idx     = k_reg[IDX_BITS-1:0];
                k_next          = k_reg - 1'b1;
                state_next      = S_UREAD;
            end
            S_REPLY:
            begin
                if (status_reg != ST_OK)
                    page_next = '0;
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        k_reg      <= k_next;
        p_reg      <= p_next;
        n_reg      <= n_next;
        page_reg   <= page_next;
        status_reg <= status_next;
        ltouch_reg <= ltouch_next;
        llen_reg   <= llen_next;
    end

    assign busy              = (state_reg != S_IDLE);
    assign done              = done_reg;
    assign result.alloc_page = page_reg;
    assign result.status     = status_reg;

endmodule

// File: rtl/core/page_extent_allocator.sv
`timescale 1ns / 1ps
// Channel   Signals                        Beat taken when
// command   start, busy, command           start && !busy
// result    done, result                   done (one cycle, no stall)
// config    cfg_we, cfg_index, cfg_data    cfg_we
//
// The extent table has one read and one write port, so scans and shifts read each entry in
// one state and then check or move it in another. A new command can be accepted in the
// cycle that shows the result.
// Reset empties the table; no clearing pass is needed.
// The result beat is shown for one cycle and cannot be held off.
module page_extent_allocator (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  pea_pkg::cmd_t                   command,
    output logic                            done,
    output pea_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [pea_pkg::CFG_BITS-1:0]    cfg_data
);
    import pea_pkg::*;

    logic [PAGE_BITS-1:0]  base_reg;
    logic [COUNT_BITS-1:0] pages_reg;
    dp_cmd_t               dcmd;
    dp_stat_t              dstat;
    logic                  busy_int;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            pages_reg <= '0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_BASE)
                base_reg <= cfg_data[PAGE_BITS-1:0];
            else if (cfg_index == REG_PAGES)
                pages_reg <= cfg_data;
        end
    end

    pea_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy_int),
        .cmd_in       (command),
        .region_base  (base_reg),
        .region_pages (pages_reg),
        .dcmd         (dcmd),
        .dstat        (dstat),
        .done         (done),
        .result       (result)
    );

    pea_table u_table (
        .clk   (clk),
        .dcmd  (dcmd),
        .dstat (dstat)
    );

    assign busy = busy_int;

endmodule
